// ===== hw/rtl/aes_pkg.sv =====
// AES-256 package: S-box, GF(2^8) doubling, round function helpers and codes.
// Used by the key expansion unit, the round unit and the top level.
package aes_pkg;

   localparam int unsigned RoundCount = 14;
   localparam int unsigned KeyWords   = 60;

   typedef enum logic [1:0] {
      CSR_KEY_0 = 2'd0,
      CSR_KEY_1 = 2'd1,
      CSR_KEY_2 = 2'd2,
      CSR_KEY_3 = 2'd3
   } csr_index_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] s [256];
      s = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return s[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

endpackage

// ===== hw/rtl/aes256_block_encrypt.sv =====
// AES-256 block encrypt top level: stream ports, key registers and round sequencer.
// Depends on aes_pkg, aes_key_expand and aes_round.
//
// The round-key memory gives one 32-bit word per cycle, so each of the 15 round
// keys is fetched as four words in the fetch state, then applied in the hold
// state: round 0 is a plain key XOR, rounds 1 to 14 use the shared round unit.
// The input is ready again on the edge that loads the result; no new block is
// taken while one is in flight. If the previous ciphertext has not been taken
// yet, the last round waits in the hold state until the result register frees
// up. A key register write expands the 60 schedule words anew, and blocks are
// held off until it ends. Key writes are taken only while no block is in flight.
module aes256_block_encrypt
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // plain_high[63:0], plain_low[127:64]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // cipher_high[63:0], cipher_low[127:64]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_HOLD  = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [255:0] key_ff, key_in;
   logic [127:0] blk_ff, blk_in;
   logic [127:0] rk_ff, rk_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [1:0]   wcnt_ff, wcnt_in;
   logic [127:0] out_ff;
   logic         out_vld_ff, out_vld_in;
   logic         load_out;
   logic         cfg_fire;
   logic [5:0]   rd_addr;
   logic [31:0]  rd_data;
   logic         kx_busy;
   logic [127:0] rnd_res;
   logic [127:0] plain;

   assign csr_ready = (state_ff == ST_IDLE);
   assign cfg_fire  = csr_valid && csr_ready;
   assign plain     = {req_tdata[63:0], req_tdata[127:64]};
   assign req_tready = (state_ff == ST_IDLE) && !kx_busy && !cfg_fire;

   // store the key word that the beat addresses
   always_comb begin
      key_in = key_ff;
      case (csr_index_type'(csr_index))
         CSR_KEY_0: key_in[255:192] = csr_data;
         CSR_KEY_1: key_in[191:128] = csr_data;
         CSR_KEY_2: key_in[127:64]  = csr_data;
         CSR_KEY_3: key_in[63:0]    = csr_data;
         default:   key_in = key_ff;
      endcase
   end

   aes_key_expand u_kx (
      .clock   (clock),
      .reset   (reset),
      .start   (cfg_fire),
      .key     (key_in),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (kx_busy)
   );

   aes_round u_round (
      .state_in  (blk_ff),
      .round_key ({rk_ff[95:0], rd_data}),
      .do_mix    (rnd_ff != 4'(RoundCount)),
      .state_out (rnd_res)
   );

   // word address: round*4 + word count
   assign rd_addr = {rnd_ff, wcnt_ff};

   // sequence: fetch four key words per round, apply in the hold state after the fourth
   always_comb begin
      state_in   = state_ff;
      blk_in     = blk_ff;
      rk_in      = rk_ff;
      rnd_in     = rnd_ff;
      wcnt_in    = wcnt_ff;
      out_vld_in = out_vld_ff;
      load_out   = 1'b0;
      if (rsp_tvalid && rsp_tready) begin
         out_vld_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               blk_in   = plain;
               rnd_in   = 4'd0;
               wcnt_in  = 2'd0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // address issued this cycle, data arrives next
            if (wcnt_ff != 2'd0) begin
               rk_in = {rk_ff[95:0], rd_data};
            end
            // hold the last word address so its data stays valid while applying
            if (wcnt_ff == 2'd3) begin
               state_in = ST_HOLD;
            end else begin
               wcnt_in = wcnt_ff + 2'd1;
            end
         end
         ST_HOLD: begin
            if (rnd_ff == 4'd0) begin
               blk_in = blk_ff ^ {rk_ff[95:0], rd_data};
            end else begin
               blk_in = rnd_res;
            end
            if (rnd_ff == 4'(RoundCount)) begin
               if (!out_vld_in) begin
                  load_out   = 1'b1;
                  out_vld_in = 1'b1;
                  wcnt_in    = 2'd0;
                  state_in   = ST_IDLE;
               end else begin
                  blk_in = blk_ff;
               end
            end else begin
               rnd_in   = rnd_ff + 4'd1;
               wcnt_in  = 2'd0;
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         key_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         if (cfg_fire) begin
            key_ff <= key_in;
         end
      end
      blk_ff  <= blk_in;
      rk_ff   <= rk_in;
      rnd_ff  <= rnd_in;
      wcnt_ff <= wcnt_in;
      if (load_out) begin
         out_ff <= rnd_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff[63:0], out_ff[127:64]};

   ap_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("accept while busy");
   ap_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> rnd_ff <= 4'(RoundCount)) else $error("round overrun");
   ap_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_vld_ff || rsp_tready)) else $error("result overwritten");
   ap_no_kx_run: assert property (@(posedge clock) disable iff (reset)
      kx_busy |-> !(req_tvalid && req_tready)) else $error("block during expansion");

endmodule

// ===== hw/rtl/aes_key_expand.sv =====
// AES-256 key expansion: one schedule word per cycle into the round-key memory.
// Depends on aes_pkg; the memory lives here and is read by the top level's sequencer.
module aes_key_expand
   import aes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [255:0] key,
   input  logic [5:0]   rd_addr,
   output logic [31:0]  rd_data,
   output logic         busy
);

   logic [31:0] mem [KeyWords];
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   logic [5:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [31:0] tmp;
   logic [31:0] nw;
   logic [31:0] wr_data;

   // next schedule word from the sliding window of the last eight
   always_comb begin
      tmp = win_ff[7];
      if (idx_ff[2:0] == 3'd0) begin
         tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'd0};
      end else if (idx_ff[2:0] == 3'd4) begin
         tmp = sub_word(tmp);
      end
      nw = win_ff[0] ^ tmp;
   end

   // load the key, store its eight words, then advance the window one word a cycle
   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      rcon_in = rcon_ff;
      win_in  = win_ff;
      wr_data = nw;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = 6'd0;
         rcon_in = 8'h01;
         for (int i = 0; i < 8; i++) begin
            win_in[i] = key[255 - 32*i -: 32];
         end
      end else if (busy_ff) begin
         if (idx_ff < 6'd8) begin
            wr_data = win_ff[idx_ff[2:0]];
         end else begin
            for (int i = 0; i < 7; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[7] = nw;
            if (idx_ff[2:0] == 3'd0) begin
               rcon_in = xtime(rcon_ff);
            end
         end
         idx_in = idx_ff + 6'd1;
         if (idx_ff == 6'(KeyWords - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      rcon_ff <= rcon_in;
      win_ff  <= win_in;
   end

   // write the schedule, read one word a cycle with registered data
   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         mem[idx_ff] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

   assign busy = busy_ff;

   ap_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < 6'(KeyWords)) else $error("schedule index overrun");
   ap_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && idx_ff == 6'(KeyWords - 1)) |=> !busy_ff)
      else $error("expansion did not stop");
   ap_start: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && idx_ff == 6'd0) else $error("expansion start lost");

endmodule

// ===== hw/rtl/aes_round.sv =====
// AES round unit: SubBytes, ShiftRows, optional MixColumns, then AddRoundKey.
// Depends on aes_pkg. Purely combinational; shared by rounds 1 to 14.
module aes_round
   import aes_pkg::*;
(
   input  logic [127:0] state_in,
   input  logic [127:0] round_key,
   input  logic         do_mix,
   output logic [127:0] state_out
);

   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];
   logic [7:0] a0, a1, a2, a3;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = state_in[127 - 8*i -: 8];
      end
      // substitute and shift rows
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[c*4 + r] = sbox(s[((c + r) % 4)*4 + r]);
         end
      end
      // mix columns
      for (int c = 0; c < 4; c++) begin
         a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
         m[c*4]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[c*4+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[c*4+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[c*4+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      for (int i = 0; i < 16; i++) begin
         state_out[127 - 8*i -: 8] = (do_mix ? m[i] : t[i]) ^ round_key[127 - 8*i -: 8];
      end
   end

endmodule

// ===== bench/aes256_block_encrypt_tb.sv =====
// Self-checking bench for the AES-256 block encrypt core: key writes, block stream, checks.
// Depends on aes_pkg for the key register codes; the cipher predictor is local.
`timescale 1ns / 100ps

module aes256_block_encrypt_tb;
   import aes_pkg::*;

   localparam bit [7:0] SUBST [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   typedef struct packed {
      logic [63:0] low;
      logic [63:0] high;
   } block_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // plain_high[63:0], plain_low[127:64]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // cipher_high[63:0], cipher_low[127:64]
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [63:0]  csr_data;

   // predictor copy of the key registers and the expanded schedule
   logic [63:0]  key_regs [4];
   logic [31:0]  sched [60];

   block_t       plain_q [$];
   block_t       cipher_q [$];
   int           error_count;
   int           beats_checked;
   int           key_writes;
   bit           gaps_on;
   int           send_gap;
   int           recv_gap;
   int           hold_ticket;
   int           hold_seen;
   int           hold_left;

   aes256_block_encrypt DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   function automatic logic [31:0] sub4(input logic [31:0] w);
      return {SUBST[w[31:24]], SUBST[w[23:16]], SUBST[w[15:8]], SUBST[w[7:0]]};
   endfunction

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // rebuild the 60-word schedule from the four key registers
   function automatic void rebuild_schedule();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 8; i++)
         sched[i] = i[0] ? key_regs[i / 2][31:0] : key_regs[i / 2][63:32];
      for (int i = 8; i < 60; i++) begin
         t = sched[i - 1];
         if (i % 8 == 0) begin
            t = sub4({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
            rcon = gf_double(rcon);
         end else if (i % 8 == 4) begin
            t = sub4(t);
         end
         sched[i] = sched[i - 8] ^ t;
      end
   endfunction

   // encrypt one block with the current schedule
   function automatic block_t encipher(input block_t p);
      logic [7:0]  s [16];
      logic [7:0]  t [16];
      logic [7:0]  a0, a1, a2, a3;
      logic [127:0] flat;
      block_t      c;
      flat = {p.high, p.low};
      for (int i = 0; i < 16; i++) s[i] = flat[127 - 8 * i -: 8];
      for (int r = 0; r <= 14; r++) begin
         if (r > 0) begin
            // substitute and shift rows
            for (int col = 0; col < 4; col++)
               for (int row = 0; row < 4; row++)
                  t[col * 4 + row] = SUBST[s[((col + row) % 4) * 4 + row]];
            s = t;
            // mix columns on all but the last round
            if (r < 14) begin
               for (int col = 0; col < 4; col++) begin
                  a0 = s[col * 4]; a1 = s[col * 4 + 1];
                  a2 = s[col * 4 + 2]; a3 = s[col * 4 + 3];
                  s[col * 4]     = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
                  s[col * 4 + 1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
                  s[col * 4 + 2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
                  s[col * 4 + 3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
               end
            end
         end
         for (int col = 0; col < 4; col++)
            for (int b = 0; b < 4; b++)
               s[col * 4 + b] ^= sched[r * 4 + col][31 - 8 * b -: 8];
      end
      for (int i = 0; i < 16; i++) flat[127 - 8 * i -: 8] = s[i];
      c.high = flat[127:64];
      c.low  = flat[63:0];
      return c;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!gaps_on || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #30ms;
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
   end

   // block driver: feed plaintext beats from the pending queue
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            cipher_q.push_back(encipher(req_tdata));
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat until it is taken
         end else if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (plain_q.size() != 0) begin
            req_tdata  <= plain_q.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_seen != hold_ticket) begin
         hold_seen <= hold_ticket;
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor: check each ciphertext beat against the oldest expectation
   always @(posedge clock) begin
      block_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (cipher_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected ciphertext high=%h low=%h", $time, got.high, got.low);
            end else begin
               want = cipher_q.pop_front();
               beats_checked++;
               if (got.high !== want.high) begin
                  error_count++;
                  $display("%0t: cipher_high expected %h actual %h", $time, want.high, got.high);
               end
               if (got.low !== want.low) begin
                  error_count++;
                  $display("%0t: cipher_low expected %h actual %h", $time, want.low, got.low);
               end
            end
         end
         if (hold_left != 0 || hold_seen != hold_ticket) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            rsp_tready <= 1'b0;
            recv_gap   <= recv_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap   <= rsp_tready ? pick_gap() : 0;
         end
      end
   end

   // write one key register and update the predictor on the beat
   task automatic write_key(input csr_index_type idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      key_regs[idx] = value;
      rebuild_schedule();
      key_writes++;
   endtask

   task automatic write_all_keys(input logic [63:0] k0, k1, k2, k3);
      write_key(CSR_KEY_0, k0);
      write_key(CSR_KEY_1, k1);
      write_key(CSR_KEY_2, k2);
      write_key(CSR_KEY_3, k3);
   endtask

   task automatic queue_block(input logic [63:0] high, input logic [63:0] low);
      block_t b;
      b.high = high;
      b.low  = low;
      plain_q.push_back(b);
   endtask

   // pause until every queued block is sent and every ciphertext is back
   task automatic drain();
      @(posedge clock);
      while (plain_q.size() != 0 || req_tvalid || cipher_q.size() != 0) @(posedge clock);
   endtask

   // main sequence
   initial begin
      int pick;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = CSR_KEY_0;
      csr_data    = '0;
      error_count = 0;
      beats_checked = 0;
      key_writes  = 0;
      hold_ticket = 0;
      gaps_on     = 1'b0;
      for (int i = 0; i < 4; i++) key_regs[i] = '0;
      rebuild_schedule();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // standard test key and vector, back to back with no idling
      write_all_keys(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                     64'h1011121314151617, 64'h18191a1b1c1d1e1f);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_block(64'h0, 64'h0);
      queue_block('1, '1);
      queue_block('1, 64'h0);
      queue_block(64'h0, '1);
      queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      drain();

      // extreme keys: all zeros, then all ones
      write_all_keys('0, '0, '0, '0);
      queue_block(64'h0, 64'h0);
      queue_block('1, '1);
      queue_block(64'h8000000000000001, 64'h0000000000000001);
      drain();
      write_all_keys('1, '1, '1, '1);
      queue_block(64'h0, 64'h0);
      queue_block('1, '1);
      queue_block(64'h0123456789abcdef, 64'hfedcba9876543210);
      drain();

      // partial key update: one register changes, the rest stay
      write_key(CSR_KEY_2, 64'h0f0e0d0c0b0a0908);
      queue_block(64'h0, 64'h0);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      write_key(CSR_KEY_0, 64'h0);
      queue_block('1, 64'h0);
      drain();

      // random phases: new key subsets, random blocks, idling on and off
      gaps_on = 1'b1;
      for (int ph = 0; ph < 12; ph++) begin
         for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 2) != 0 || ph % 4 == 0) begin
               pick = $urandom_range(0, 9);
               write_key(csr_index_type'(i),
                         pick == 0 ? 64'h0 : pick == 1 ? '1 : rand64());
            end
         end
         gaps_on = (ph % 3 != 2);
         for (int n = 0; n < 107; n++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) queue_block(64'h0, rand64());
            else if (pick == 1) queue_block(rand64(), '1);
            else queue_block(rand64(), rand64());
         end
         // stall the receiver for a long stretch while blocks keep coming
         if (ph == 3 || ph == 8) begin
            @(posedge clock);
            hold_ticket <= hold_ticket + 1;
         end
         drain();
      end

      repeat (100) @(posedge clock);
      $display("checked %0d ciphertext beats across %0d key register writes",
               beats_checked, key_writes);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
